/* src/rgb_matrix_row_scan_driver_macros.svh */
// assertion macros shared by the scan driver rtl
`ifndef RGB_MATRIX_ROW_SCAN_DRIVER_MACROS_SVH
`define RGB_MATRIX_ROW_SCAN_DRIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RMSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RMSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rmsd_pkg.sv */
// shared constants and types of the led matrix row scan driver
`timescale 1ns / 1ps

package rmsd_pkg;

    // panel geometry
    localparam int PANEL_WIDTH = 32;
    localparam int SCAN_ROWS   = 16;
    localparam int MAX_PANELS  = 2;
    localparam int MAX_SHIFT   = 64;

    localparam int STORE_COLS  = PANEL_WIDTH * MAX_PANELS;
    localparam int STORE_ROWS  = 2 * SCAN_ROWS;

    // field widths
    localparam int COL_W   = 6;
    localparam int PROW_W  = 5;
    localparam int LEVEL_W = 8;
    localparam int PNL_W   = 2;
    localparam int ROW_W   = $clog2(SCAN_ROWS);
    localparam int SCOL_W  = $clog2(STORE_COLS);
    localparam int WID_W   = $clog2(STORE_COLS + 1);
    localparam int PIX_W   = 3;

    // one half-frame memory: bank, scan row, column
    localparam int ADDR_W  = 1 + ROW_W + SCOL_W;
    localparam int DEPTH   = 2 ** ADDR_W;

    // input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    // command to both half-frame memories
    typedef struct packed {
        logic              we_up;
        logic              we_lo;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_cmd;

    // side data of the word in the output register
    typedef struct packed {
        logic             vld;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             latch;
    } t_out_meta;

endpackage

/* src/rmsd_ram.sv */
// half-frame pixel memory, one write port and one registered read port
`timescale 1ns / 1ps

module rmsd_ram import rmsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [PIX_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rmsd_ctrl.sv */
// sequencer: clearing pass, pixel writes, row scan and bank swap
`timescale 1ns / 1ps

module rmsd_ctrl import rmsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [COL_W-1:0]   i_pixel_column,
    input  logic [PROW_W-1:0]  i_pixel_row,
    input  logic [LEVEL_W-1:0] i_red_level,
    input  logic [LEVEL_W-1:0] i_green_level,
    input  logic [LEVEL_W-1:0] i_blue_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PNL_W-1:0]   i_cfg_data,
    input  logic               i_out_stall,
    output t_ram_cmd           o_ram_cmd,
    output t_out_meta          o_meta
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [SCOL_W-1:0] r_col;
    logic [ROW_W-1:0]  r_scan_row;
    logic              r_front;
    logic [PNL_W-1:0]  r_panel_count;
    logic              r_out_vld;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_latch;

    logic [PNL_W-1:0]  w_panels;
    logic [WID_W-1:0]  w_width;
    logic [WID_W-1:0]  w_cols;
    logic              w_accept;
    logic              w_issue;
    logic              w_last;
    logic              w_wr_ok;
    logic              w_clr_done;

    // active width from the panel count, zero acts as one panel and three as two
    always_comb begin
        priority if (r_panel_count == '0) begin
            w_panels = PNL_W'(1);
        end else if (r_panel_count > PNL_W'(MAX_PANELS)) begin
            w_panels = PNL_W'(MAX_PANELS);
        end else begin
            w_panels = r_panel_count;
        end
        w_width = WID_W'(int'(w_panels) * PANEL_WIDTH);
        w_cols  = (w_width > WID_W'(MAX_SHIFT)) ? WID_W'(MAX_SHIFT) : w_width;
    end

    // handshakes and scan issue
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_issue     = (r_state == ST_SCAN) && (!r_out_vld || !i_out_stall);
    assign w_last      = ({1'b0, r_col} == (w_cols - WID_W'(1)));
    assign w_clr_done  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign w_wr_ok     = w_accept && (i_func == FUNC_WRITE)
                         && ({1'b0, i_pixel_column} < w_width)
                         && ({1'b0, i_pixel_row} < (PROW_W + 1)'(STORE_ROWS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && (i_func == FUNC_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_issue && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_count <= PNL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_panel_count <= i_cfg_data;
        end
    end

    // column counter, scan row and displayed bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_scan_row <= '0;
            r_front    <= 1'b0;
        end else begin
            if (w_accept && (i_func == FUNC_TICK)) begin
                r_col <= '0;
            end else if (w_issue) begin
                r_col <= r_col + SCOL_W'(1);
            end
            if (w_issue && w_last) begin
                if (r_scan_row == ROW_W'(SCAN_ROWS - 1)) begin
                    r_scan_row <= '0;
                    r_front    <= ~r_front;
                end else begin
                    r_scan_row <= r_scan_row + ROW_W'(1);
                end
            end
        end
    end

    // output word valid, follows the memory read register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_issue) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // side data captured with each read
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_row   <= r_scan_row;
            r_out_col   <= COL_W'(r_col);
            r_out_latch <= w_last;
        end
    end

    // memory commands: clearing pass or pixel write, scan read
    always_comb begin
        o_ram_cmd = '0;
        if (r_state == ST_CLEAR) begin
            o_ram_cmd.we_up = 1'b1;
            o_ram_cmd.we_lo = 1'b1;
            o_ram_cmd.waddr = r_clr_addr;
            o_ram_cmd.wdata = '0;
        end else begin
            o_ram_cmd.we_up = w_wr_ok && !i_pixel_row[ROW_W];
            o_ram_cmd.we_lo = w_wr_ok && i_pixel_row[ROW_W];
            o_ram_cmd.waddr = {~r_front, i_pixel_row[ROW_W-1:0], SCOL_W'(i_pixel_column)};
            o_ram_cmd.wdata = {i_blue_level[LEVEL_W-1], i_green_level[LEVEL_W-1],
                               i_red_level[LEVEL_W-1]};
        end
        o_ram_cmd.re    = w_issue;
        o_ram_cmd.raddr = {r_front, r_scan_row, r_col};
    end

    assign o_meta.vld   = r_out_vld;
    assign o_meta.row   = r_out_row;
    assign o_meta.col   = r_out_col;
    assign o_meta.latch = r_out_latch;

endmodule

/* src/rgb_matrix_row_scan_driver.sv */
// top level of the led matrix row scan driver
//
// Input channel (i_in_valid / o_in_stall): a word with i_func = write stores
// one pixel, each colour lit when its level is at least 128, into the back
// bank and gives no output. Columns at or beyond the width set by the panel
// count are dropped. A word with i_func = tick scans the current row pair
// from the front bank and gives one output word per column, 32 or 64 of
// them, the last one with o_latch_now set.
// Output channel (o_out_valid / i_out_stall): the first column is valid once
// the tick has moved the sequencer into its scan state and the memory read
// registers have been loaded, then one column a cycle while not stalled; a
// stall holds the word and the scan. The next word is taken while the last
// column still waits. After row 15 the scan row wraps and the banks swap.
// Config channel (i_cfg_valid / o_cfg_ready): writes the panel count, always
// ready. Reset clears the pixel memories in a pass over every address while
// the input stalls; the pixel memory read port sets the one column per
// cycle rate.
`timescale 1ns / 1ps

`include "rgb_matrix_row_scan_driver_macros.svh"

module rgb_matrix_row_scan_driver import rmsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [COL_W-1:0]   i_pixel_column,
    input  logic [PROW_W-1:0]  i_pixel_row,
    input  logic [LEVEL_W-1:0] i_red_level,
    input  logic [LEVEL_W-1:0] i_green_level,
    input  logic [LEVEL_W-1:0] i_blue_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PNL_W-1:0]   i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_upper_red,
    output logic               o_upper_green,
    output logic               o_upper_blue,
    output logic               o_lower_red,
    output logic               o_lower_green,
    output logic               o_lower_blue,
    output logic [3:0]         o_row_address,
    output logic [COL_W-1:0]   o_shift_column,
    output logic               o_latch_now
);

    t_ram_cmd         w_cmd;
    t_out_meta        w_meta;
    logic [PIX_W-1:0] w_up_pix;
    logic [PIX_W-1:0] w_lo_pix;

    // sequencer
    rmsd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_red_level    (i_red_level),
        .i_green_level  (i_green_level),
        .i_blue_level   (i_blue_level),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_ram_cmd      (w_cmd),
        .o_meta         (w_meta)
    );

    // upper half rows
    rmsd_ram u_ram_up (
        .i_clk   (i_clk),
        .i_we    (w_cmd.we_up),
        .i_waddr (w_cmd.waddr),
        .i_wdata (w_cmd.wdata),
        .i_re    (w_cmd.re),
        .i_raddr (w_cmd.raddr),
        .o_rdata (w_up_pix)
    );

    // lower half rows
    rmsd_ram u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (w_cmd.we_lo),
        .i_waddr (w_cmd.waddr),
        .i_wdata (w_cmd.wdata),
        .i_re    (w_cmd.re),
        .i_raddr (w_cmd.raddr),
        .o_rdata (w_lo_pix)
    );

    // output word straight from the memory read registers
    assign o_out_valid    = w_meta.vld;
    assign o_upper_red    = w_up_pix[0];
    assign o_upper_green  = w_up_pix[1];
    assign o_upper_blue   = w_up_pix[2];
    assign o_lower_red    = w_lo_pix[0];
    assign o_lower_green  = w_lo_pix[1];
    assign o_lower_blue   = w_lo_pix[2];
    assign o_row_address  = 4'(w_meta.row);
    assign o_shift_column = w_meta.col;
    assign o_latch_now    = w_meta.latch;

    // checks on the scan sequence
    `RMSD_ASSERT_IMP(a_latch_col, o_out_valid && o_latch_now,
        o_shift_column == COL_W'(PANEL_WIDTH - 1) || o_shift_column == COL_W'(STORE_COLS - 1),
        "latch not on a last column")
    `RMSD_ASSERT_NXT(a_row_stream, o_out_valid && !i_out_stall && !o_latch_now,
        o_out_valid && o_shift_column == $past(o_shift_column) + COL_W'(1),
        "row scan broke off")
    `RMSD_ASSERT_IMP(a_idle_tail, o_out_valid && !o_in_stall, o_latch_now, "input taken mid row")

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the led matrix row scan driver
`timescale 1ns / 1ps

module testbench;
    import rmsd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int TICK_PERCENT  = 35;
    localparam int NUM_PHASES    = 5;

    // panel count per random phase and word count per phase
    localparam int PHASE_PANELS [NUM_PHASES] = '{2, 0, 3, 1, 2};
    localparam int PHASE_WORDS  [NUM_PHASES] = '{25, 15, 20, 15, 20};

    // one input word as queued for the driver
    typedef struct {
        logic               func;
        logic [COL_W-1:0]   column;
        logic [PROW_W-1:0]  row;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        bit                 hold_for_drain;
    } t_in_word;

    // one shifted column pair
    typedef struct {
        logic             upper_red;
        logic             upper_green;
        logic             upper_blue;
        logic             lower_red;
        logic             lower_green;
        logic             lower_blue;
        logic [3:0]       row_address;
        logic [COL_W-1:0] column;
        logic             latch;
    } t_shift_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_func = FUNC_WRITE;
    logic [COL_W-1:0]   i_pixel_column = '0;
    logic [PROW_W-1:0]  i_pixel_row = '0;
    logic [LEVEL_W-1:0] i_red_level = '0;
    logic [LEVEL_W-1:0] i_green_level = '0;
    logic [LEVEL_W-1:0] i_blue_level = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [PNL_W-1:0]   i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_upper_red;
    logic               o_upper_green;
    logic               o_upper_blue;
    logic               o_lower_red;
    logic               o_lower_green;
    logic               o_lower_blue;
    logic [3:0]         o_row_address;
    logic [COL_W-1:0]   o_shift_column;
    logic               o_latch_now;

    // predicted state of the block
    logic [PIX_W-1:0] frame_mem [2][STORE_ROWS][STORE_COLS];
    bit               front_bank;
    int               scan_row;
    logic [PNL_W-1:0] panel_setting;

    t_in_word    pending_words[$];
    t_shift_word expected_columns[$];
    t_in_word    word_on_bus;
    int          fail_count = 0;
    int          burst_left = 8;
    int          gap_left = 0;
    int          stall_clock = 0;

    rgb_matrix_row_scan_driver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_red_level    (i_red_level),
        .i_green_level  (i_green_level),
        .i_blue_level   (i_blue_level),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_upper_red    (o_upper_red),
        .o_upper_green  (o_upper_green),
        .o_upper_blue   (o_upper_blue),
        .o_lower_red    (o_lower_red),
        .o_lower_green  (o_lower_green),
        .o_lower_blue   (o_lower_blue),
        .o_row_address  (o_row_address),
        .o_shift_column (o_shift_column),
        .o_latch_now    (o_latch_now)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // display width in columns, out-of-range counts clamp to 1..MAX_PANELS
    function automatic int display_width();
        int n;
        n = panel_setting;
        if (n < 1)
            n = 1;
        if (n > MAX_PANELS)
            n = MAX_PANELS;
        return n * PANEL_WIDTH;
    endfunction

    // store a pixel or scan one row pair, queueing the columns it shifts out
    function automatic void store_or_scan(input t_in_word w);
        int               width;
        int               cols;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lo;
        t_shift_word      col_word;
        width = display_width();
        if (w.func == FUNC_WRITE) begin
            // lit at 128 and above, i.e. the top bit of the level
            if (w.column < width && w.row < STORE_ROWS)
                frame_mem[front_bank ^ 1'b1][w.row][w.column] =
                    {w.blue[LEVEL_W-1], w.green[LEVEL_W-1], w.red[LEVEL_W-1]};
        end else begin
            cols = (width < MAX_SHIFT) ? width : MAX_SHIFT;
            for (int c = 0; c < cols; c++) begin
                up = frame_mem[front_bank][scan_row][c];
                lo = frame_mem[front_bank][scan_row + SCAN_ROWS][c];
                col_word.upper_red   = up[0];
                col_word.upper_green = up[1];
                col_word.upper_blue  = up[2];
                col_word.lower_red   = lo[0];
                col_word.lower_green = lo[1];
                col_word.lower_blue  = lo[2];
                col_word.row_address = scan_row[3:0];
                col_word.column      = c[COL_W-1:0];
                col_word.latch       = (c + 1 == cols);
                expected_columns.push_back(col_word);
            end
            // wrap after the last row pair and swap banks
            if (scan_row == SCAN_ROWS - 1) begin
                scan_row   = 0;
                front_bank = ~front_bank;
            end else begin
                scan_row++;
            end
        end
    endfunction

    function automatic t_in_word make_word(input logic func, input int col, input int row,
                                           input int r, input int g, input int b,
                                           input bit hold);
        t_in_word w;
        w.func           = func;
        w.column         = col[COL_W-1:0];
        w.row            = row[PROW_W-1:0];
        w.red            = r[LEVEL_W-1:0];
        w.green          = g[LEVEL_W-1:0];
        w.blue           = b[LEVEL_W-1:0];
        w.hold_for_drain = hold;
        return w;
    endfunction

    // levels weighted toward the threshold edges
    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 127;
            2: return 128;
            3: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // random mix of pixel writes and ticks, most writes inside the width
    function automatic t_in_word random_word(input int width);
        logic func;
        int   col;
        func = ($urandom_range(0, 99) < TICK_PERCENT) ? FUNC_TICK : FUNC_WRITE;
        if ($urandom_range(0, 3) != 0)
            col = $urandom_range(0, width - 1);
        else
            col = $urandom_range(0, STORE_COLS - 1);
        return make_word(func, col, $urandom_range(0, STORE_ROWS - 1), pick_level(),
                         pick_level(), pick_level(), $urandom_range(0, 19) == 0);
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // wait until every queued word is taken and every column has come out
    task automatic wait_for_drain();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_columns.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_panel_count(input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[PNL_W-1:0];
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        panel_setting = value[PNL_W-1:0];
        i_cfg_valid   <= 1'b0;
    endtask

    // input driver: bursts with random gaps, one word per accepted slot
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                store_or_scan(word_on_bus);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() == 0 ||
                             (pending_words[0].hold_for_drain &&
                              expected_columns.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    word_on_bus = pending_words.pop_front();
                    i_in_valid     <= 1'b1;
                    i_func         <= word_on_bus.func;
                    i_pixel_column <= word_on_bus.column;
                    i_pixel_row    <= word_on_bus.row;
                    i_red_level    <= word_on_bus.red;
                    i_green_level  <= word_on_bus.green;
                    i_blue_level   <= word_on_bus.blue;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // output monitor and receiver stall pattern
    always @(posedge i_clk) begin : out_monitor
        t_shift_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_columns.size() == 0) begin
                    $display("%0t: unexpected word, actual row %0h column %0h",
                             $time, o_row_address, o_shift_column);
                    fail_count++;
                end else begin
                    want = expected_columns.pop_front();
                    compare_field("upper_red", want.upper_red, o_upper_red);
                    compare_field("upper_green", want.upper_green, o_upper_green);
                    compare_field("upper_blue", want.upper_blue, o_upper_blue);
                    compare_field("lower_red", want.lower_red, o_lower_red);
                    compare_field("lower_green", want.lower_green, o_lower_green);
                    compare_field("lower_blue", want.lower_blue, o_lower_blue);
                    compare_field("row_address", want.row_address, o_row_address);
                    compare_field("shift_column", want.column, o_shift_column);
                    compare_field("latch_now", want.latch, o_latch_now);
                end
            end
            // free run, light random, heavy random, then a fixed rhythm
            stall_clock++;
            case ((stall_clock / 150) % 4)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= ((stall_clock % 5) < 2);
            endcase
        end
    end

    // sequence: reset, directed words, then random phases at several widths
    initial begin
        for (int b = 0; b < 2; b++)
            for (int r = 0; r < STORE_ROWS; r++)
                for (int c = 0; c < STORE_COLS; c++)
                    frame_mem[b][r][c] = '0;
        front_bank    = 1'b0;
        scan_row      = 0;
        panel_setting = 1;

        // directed: threshold edges, columns past the width, full frame to swap banks
        pending_words.push_back(make_word(FUNC_WRITE, 0, 0, 255, 255, 255, 0));
        pending_words.push_back(make_word(FUNC_WRITE, 31, 16, 128, 0, 127, 0));
        pending_words.push_back(make_word(FUNC_WRITE, 5, 0, 127, 128, 255, 0));
        pending_words.push_back(make_word(FUNC_WRITE, 32, 1, 255, 255, 255, 0));
        pending_words.push_back(make_word(FUNC_WRITE, 63, 31, 255, 255, 255, 0));
        pending_words.push_back(make_word(FUNC_WRITE, 10, 16, 0, 255, 0, 0));
        for (int t = 0; t <= SCAN_ROWS; t++)
            pending_words.push_back(make_word(FUNC_TICK, 63, 31, 255, 255, 255, t == 8));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_drain();
            write_panel_count(PHASE_PANELS[p]);
            @(negedge i_clk);
            for (int k = 0; k < PHASE_WORDS[p]; k++)
                pending_words.push_back(random_word(display_width()));
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/rmsd_pkg.sv
src/rmsd_ram.sv
src/rmsd_ctrl.sv
src/rgb_matrix_row_scan_driver.sv
tb/sv/testbench.sv
